>>> hw/rtl/mit_pkg.sv
// ----------------------------------------------------------------------------
// Multichannel interval timer package
// Shared constants and codes for the multichannel interval timer.
// ----------------------------------------------------------------------------
package mit_pkg;

  // Number of measurement channels. The channel field is 4 bits wide.
  localparam int CHANNELS = 16;

  // Field widths.
  localparam int MODE_W    = 2;
  localparam int CHANNEL_W = 4;
  localparam int CAPTURE_W = 16;
  localparam int COUNT_W   = 16;
  localparam int ELAPSED_W = 32;

  // Event codes carried by the mode field.
  localparam logic [MODE_W-1:0] MODE_START = 2'd0;
  localparam logic [MODE_W-1:0] MODE_STOP  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_LAP   = 2'd2;
  localparam logic [MODE_W-1:0] MODE_TICK  = 2'd3;

  typedef logic [COUNT_W-1:0] count_t;

endpackage

>>> hw/rtl/multichannel_interval_timer.sv
// ----------------------------------------------------------------------------
// Multichannel interval timer
// Stopwatch with several channels on a free-running 16-bit capture timer.
// Each channel keeps a start capture and an overflow count; stop and lap
// report (count << 16) + capture - start as a 32-bit two's complement value.
// ----------------------------------------------------------------------------
//
//  Channel  Handshake           Payload
//  -------  ------------------  -------------------------------------
//  input    in_valid/in_stall   mode, channel, capture_value
//  output   out_valid/out_stall elapsed
//
// One beat is accepted per cycle unless the input stalls; its result is in
// the output register in the cycle after acceptance, and every beat gives
// exactly one result beat. The channel state and the elapsed result are
// computed in the same cycle from the incoming beat, so one add and one
// subtract set the cycle time. Synchronous reset clears all start captures
// and overflow counts. The input stalls only while a result waits in the
// output register and the output side stalls.

module multichannel_interval_timer (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [mit_pkg::MODE_W-1:0]       mode,
  input  logic [mit_pkg::CHANNEL_W-1:0]    channel,
  input  logic [mit_pkg::CAPTURE_W-1:0]    capture_value,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic signed [mit_pkg::ELAPSED_W-1:0] elapsed
);

  // Per-channel state.
  mit_pkg::count_t start_count    [mit_pkg::CHANNELS];
  mit_pkg::count_t overflow_count [mit_pkg::CHANNELS];

  logic                                accept;
  logic                                channel_ok;
  logic                                is_tick;
  logic                                do_restart;
  logic [mit_pkg::ELAPSED_W-1:0]       span;
  logic [mit_pkg::ELAPSED_W-1:0]       elapsed_next;
  mit_pkg::count_t                     sel_start;
  mit_pkg::count_t                     sel_overflow;

  // Handshake: hold off the input while a result waits and is stalled.
  assign in_stall = out_valid && out_stall;
  assign accept   = in_valid && !in_stall;

  // Decode the event.
  assign is_tick    = (mode == mit_pkg::MODE_TICK);
  assign channel_ok = (32'(channel) < mit_pkg::CHANNELS);
  assign do_restart = accept && channel_ok &&
                      ((mode == mit_pkg::MODE_START) || (mode == mit_pkg::MODE_LAP));

  // Read the addressed channel.
  always_comb begin
    sel_start    = '0;
    sel_overflow = '0;
    for (int i = 0; i < mit_pkg::CHANNELS; i++) begin
      if (32'(channel) == i) begin
        sel_start    = start_count[i];
        sel_overflow = overflow_count[i];
      end
    end
  end

  // Elapsed ticks, taken modulo 2^32.
  assign span = {sel_overflow, {mit_pkg::CAPTURE_W{1'b0}}}
              + {{(mit_pkg::ELAPSED_W-mit_pkg::CAPTURE_W){1'b0}}, capture_value}
              - {{(mit_pkg::ELAPSED_W-mit_pkg::COUNT_W){1'b0}}, sel_start};

  always_comb begin
    elapsed_next = '0;
    if (channel_ok && ((mode == mit_pkg::MODE_STOP) || (mode == mit_pkg::MODE_LAP))) begin
      elapsed_next = span;
    end
  end

  // Channel state update: a tick advances every count, start and lap restart one.
  for (genvar g = 0; g < mit_pkg::CHANNELS; g++) begin : g_chan
    always_ff @(posedge clk) begin
      if (rst) begin
        start_count[g]    <= '0;
        overflow_count[g] <= '0;
      end else if (accept && is_tick) begin
        overflow_count[g] <= overflow_count[g] + mit_pkg::count_t'(1);
      end else if (do_restart && (32'(channel) == g)) begin
        start_count[g]    <= capture_value;
        overflow_count[g] <= '0;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      elapsed <= elapsed_next;
    end
  end

  // The input stalls only behind a waiting result.
  assert property (@(posedge clk) disable iff (rst) in_stall |-> out_valid)
    else $error("input stalled with no result waiting");

  // Start and tick beats report zero.
  assert property (@(posedge clk) disable iff (rst)
    accept && ((mode == mit_pkg::MODE_START) || (mode == mit_pkg::MODE_TICK))
    |=> out_valid && (elapsed == '0))
    else $error("start or tick reported a nonzero elapsed value");

  // A stop right after a start on the same channel at the same capture gives zero.
  assert property (@(posedge clk) disable iff (rst)
    (accept && (mode == mit_pkg::MODE_START)) ##1
    (accept && (mode == mit_pkg::MODE_STOP) && (channel == $past(channel)) &&
     (capture_value == $past(capture_value)))
    |=> (elapsed == '0))
    else $error("stop after start at the same capture is not zero");

endmodule
